// File: src/cqst_pkg.sv
// Package for the client quota session table: function and event codes, byte-mode time quota and report limit.
// No dependencies.
package cqst_pkg;
  localparam logic [2:0] FN_CREATE_TIME = 3'd0;
  localparam logic [2:0] FN_CREATE_BYTES = 3'd1;
  localparam logic [2:0] FN_ADD_BYTES = 3'd2;
  localparam logic [2:0] FN_TICK = 3'd3;
  localparam logic [2:0] FN_REVOKE_ALL = 3'd4;
  localparam logic [2:0] FN_QUERY = 3'd5;
  localparam logic [2:0] EV_GRANTED = 3'd0;
  localparam logic [2:0] EV_EXTENDED = 3'd1;
  localparam logic [2:0] EV_REVOKED = 3'd2;
  localparam logic [2:0] EV_NO_SLOT = 3'd3;
  localparam logic [2:0] EV_DONE = 3'd4;
  localparam logic [2:0] EV_LIVE = 3'd5;
  localparam logic [2:0] EV_EXPIRED = 3'd6;
  localparam logic [2:0] EV_NOT_FOUND = 3'd7;
  localparam logic [63:0] BYTE_TIME_QUOTA = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int MAX_REPORTS = 16;
endpackage

// File: src/client_quota_session_table.sv
// Client quota session table: slots walked one a cycle unless a result waits.
// Depends on cqst_pkg.
//
//  channel  | signals                               | dir
//  in       | in_valid in_stall func host_ip amount | in
//  out      | out_valid out_stall event_res result_ip slot_index active_count last | out
//  cfg      | cfg_valid cfg_ready cfg_data          | in
//
// An item walks the slot table; a create in a full table walks it up to three times.
// Each result waits in the output register; the walk holds while it is stalled.
// Reset clears valid bits, clock and count; slot payload is undefined until written.
module client_quota_session_table #(
  parameter int MAX_SESSIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] host_ip,
  input  logic [63:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [31:0] result_ip,
  output logic [3:0]  slot_index,
  output logic [4:0]  active_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  localparam int IW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CW = $clog2(MAX_SESSIONS + 1);
  localparam int RW = $clog2(cqst_pkg::MAX_REPORTS + 1);
  localparam logic [IW-1:0] LAST_IX = IW'(MAX_SESSIONS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_EVICT, S_ALLOC, S_SWEEP, S_WAIT
  } state_t;

  state_t state;
  logic metric_is_bytes;
  logic [MAX_SESSIONS-1:0] slot_active;
  logic [31:0] slot_ip [MAX_SESSIONS];
  logic [63:0] slot_time_quota [MAX_SESSIONS];
  logic [63:0] slot_start_time [MAX_SESSIONS];
  logic [63:0] slot_byte_quota [MAX_SESSIONS];
  logic [63:0] slot_bytes_used [MAX_SESSIONS];
  logic [MAX_SESSIONS-1:0] slot_is_byte_mode;
  logic [63:0] clock_ms;
  logic [CW-1:0] live_count;
  logic [2:0] op;
  logic [31:0] ip;
  logic [63:0] amt;
  logic [IW-1:0] ix;
  logic [RW-1:0] nrep;
  logic done_after;

  logic expired;
  logic [63:0] cur_tq, cur_bu, tq_sum, bu_sum;
  logic [64:0] tq_add, bu_add;
  logic ip_hit;
  logic at_end;

  assign cur_tq = slot_time_quota[ix];
  assign cur_bu = slot_bytes_used[ix];
  assign tq_add = {1'b0, cur_tq} + {1'b0, amt};
  assign bu_add = {1'b0, cur_bu} + {1'b0, amt};
  assign tq_sum = tq_add[64] ? '1 : tq_add[63:0];
  assign bu_sum = bu_add[64] ? '1 : bu_add[63:0];
  assign ip_hit = slot_active[ix] && slot_ip[ix] == ip;
  assign at_end = ix == LAST_IX;

  always_comb begin
    if (!slot_active[ix]) expired = 1'b1;
    else if (slot_is_byte_mode[ix] || metric_is_bytes) expired = cur_bu >= slot_byte_quota[ix];
    else expired = (clock_ms - slot_start_time[ix]) >= cur_tq;
  end

  assign in_stall = state != S_IDLE;
  assign cfg_ready = state == S_IDLE;
  assign active_count = 5'(live_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      metric_is_bytes <= 1'b0;
      slot_active <= '0;
      clock_ms <= '0;
      live_count <= '0;
      out_valid <= 1'b0;
      done_after <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) metric_is_bytes <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= func;
            ip <= host_ip;
            amt <= amount;
            ix <= '0;
            nrep <= '0;
            case (func)
              cqst_pkg::FN_CREATE_TIME, cqst_pkg::FN_CREATE_BYTES,
              cqst_pkg::FN_ADD_BYTES, cqst_pkg::FN_QUERY: state <= S_FIND;
              cqst_pkg::FN_TICK: begin
                if (clock_ms != '1) clock_ms <= clock_ms + 64'd1;
                state <= S_SWEEP;
              end
              cqst_pkg::FN_REVOKE_ALL: state <= S_SWEEP;
              default: begin
                out_valid <= 1'b1;
                event_res <= cqst_pkg::EV_DONE;
                result_ip <= host_ip;
                slot_index <= '0;
                last <= 1'b1;
                state <= S_WAIT;
              end
            endcase
          end
        end
        S_FIND: begin
          if (ip_hit) begin
            out_valid <= 1'b1;
            result_ip <= ip;
            slot_index <= 4'(ix);
            last <= 1'b1;
            state <= S_WAIT;
            case (op)
              cqst_pkg::FN_ADD_BYTES: begin
                slot_bytes_used[ix] <= bu_sum;
                event_res <= cqst_pkg::EV_DONE;
              end
              cqst_pkg::FN_QUERY:
                event_res <= expired ? cqst_pkg::EV_EXPIRED : cqst_pkg::EV_LIVE;
              default: begin
                event_res <= cqst_pkg::EV_EXTENDED;
                if (op == cqst_pkg::FN_CREATE_BYTES) begin
                  slot_byte_quota[ix] <= amt;
                  slot_bytes_used[ix] <= '0;
                  slot_time_quota[ix] <= cqst_pkg::BYTE_TIME_QUOTA;
                  slot_is_byte_mode[ix] <= 1'b1;
                end else slot_time_quota[ix] <= tq_sum;
              end
            endcase
          end else if (at_end) begin
            ix <= '0;
            if (op == cqst_pkg::FN_ADD_BYTES || op == cqst_pkg::FN_QUERY) begin
              out_valid <= 1'b1;
              event_res <= cqst_pkg::EV_NOT_FOUND;
              result_ip <= ip;
              slot_index <= '0;
              last <= 1'b1;
              state <= S_WAIT;
            end else if (live_count >= CW'(MAX_SESSIONS)) state <= S_EVICT;
            else state <= S_ALLOC;
          end else ix <= ix + 1'b1;
        end
        S_EVICT: begin
          if (!slot_active[ix] || at_end && !expired) begin
            ix <= '0;
            state <= S_ALLOC;
          end else if (expired) begin
            slot_active[ix] <= 1'b0;
            live_count <= live_count - 1'b1;
            out_valid <= 1'b1;
            event_res <= cqst_pkg::EV_REVOKED;
            result_ip <= slot_ip[ix];
            slot_index <= 4'(ix);
            last <= 1'b0;
            done_after <= 1'b0;
            ix <= '0;
            state <= S_WAIT;
          end else ix <= ix + 1'b1;
        end
        S_ALLOC: begin
          if (!slot_active[ix]) begin
            slot_active[ix] <= 1'b1;
            slot_ip[ix] <= ip;
            slot_start_time[ix] <= clock_ms;
            slot_bytes_used[ix] <= '0;
            if (op == cqst_pkg::FN_CREATE_BYTES) begin
              slot_byte_quota[ix] <= amt;
              slot_time_quota[ix] <= cqst_pkg::BYTE_TIME_QUOTA;
              slot_is_byte_mode[ix] <= 1'b1;
            end else begin
              slot_byte_quota[ix] <= '0;
              slot_time_quota[ix] <= amt;
              slot_is_byte_mode[ix] <= 1'b0;
            end
            live_count <= live_count + 1'b1;
            out_valid <= 1'b1;
            event_res <= cqst_pkg::EV_GRANTED;
            result_ip <= ip;
            slot_index <= 4'(ix);
            last <= 1'b1;
            state <= S_WAIT;
          end else if (at_end) begin
            out_valid <= 1'b1;
            event_res <= cqst_pkg::EV_NO_SLOT;
            result_ip <= ip;
            slot_index <= '0;
            last <= 1'b1;
            state <= S_WAIT;
          end else ix <= ix + 1'b1;
        end
        S_SWEEP: begin
          if (ix == '0 && done_after) begin
            done_after <= 1'b0;
            out_valid <= 1'b1;
            event_res <= cqst_pkg::EV_DONE;
            result_ip <= '0;
            slot_index <= '0;
            last <= 1'b1;
            state <= S_WAIT;
          end else begin
            if (at_end) begin
              ix <= '0;
              done_after <= 1'b1;
            end else ix <= ix + 1'b1;
            if (slot_active[ix] && (op == cqst_pkg::FN_REVOKE_ALL || expired)) begin
              slot_active[ix] <= 1'b0;
              if (live_count != '0) live_count <= live_count - 1'b1;
              if (nrep < RW'(cqst_pkg::MAX_REPORTS)) begin
                nrep <= nrep + 1'b1;
                out_valid <= 1'b1;
                event_res <= cqst_pkg::EV_REVOKED;
                result_ip <= slot_ip[ix];
                slot_index <= 4'(ix);
                last <= 1'b0;
                state <= S_WAIT;
              end
            end
          end
        end
        S_WAIT: begin
          if (!out_stall) begin
            if (last) state <= S_IDLE;
            else if (op == cqst_pkg::FN_TICK || op == cqst_pkg::FN_REVOKE_ALL)
              state <= S_SWEEP;
            else state <= S_ALLOC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_WAIT) else $error("result outside wait");
  a_count: assert property (@(posedge clk) disable iff (rst)
    live_count == CW'($countones(slot_active))) else $error("count mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res)) else $error("result lost");
endmodule
